// ===== rtl/grp_pkg.sv =====
// shared types and constants of the guillotine rectangle packer
// no dependencies
package grp_pkg;

    localparam int CW       = 12;
    localparam int IDX_BITS = 8;

    localparam logic [1:0] KIND_PLACED   = 2'd0;
    localparam logic [1:0] KIND_SKIPPED  = 2'd1;
    localparam logic [1:0] KIND_INTERNAL = 2'd2;
    localparam logic [1:0] KIND_EXTERNAL = 2'd3;

    localparam logic [1:0] REG_SHEET_W = 2'd0;
    localparam logic [1:0] REG_SHEET_H = 2'd1;

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [CW-1:0] w;
        logic [CW-1:0] h;
    } t_rect;

    typedef struct packed {
        logic  v;
        t_rect r;
    } t_slot;

    // best-fit search state handed from cell to cell
    typedef struct packed {
        logic [CW-1:0]       dwmin;
        logic [CW-1:0]       dhmin;
        logic                found;
        logic                done;
        logic [IDX_BITS-1:0] idx;
        t_rect               r;
    } t_probe;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_PUSH,
        OP_REMOVE,
        OP_POP,
        OP_CLEAR
    } t_cell_op;

    typedef struct packed {
        t_cell_op            op;
        logic [IDX_BITS-1:0] rm_idx;
        logic [CW-1:0]       w;
        logic [CW-1:0]       h;
    } t_cell_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PLACE,
        S_PUSH1,
        S_PUSH2,
        S_PIECE,
        S_DUMP,
        S_EXT
    } t_state;

endpackage

// ===== rtl/grp_if.sv =====
// channel interfaces of the guillotine rectangle packer
// depends on grp_pkg
interface grp_item_if;
    logic                     valid;
    logic                     ready;
    logic [grp_pkg::CW-1:0]   piece_width;
    logic [grp_pkg::CW-1:0]   piece_height;
    logic [9:0]               piece_type;
    logic                     include_req;
    logic                     rotate;
    logic                     last;
    modport source (output valid, piece_width, piece_height, piece_type, include_req,
                    rotate, last, input ready);
    modport sink (input valid, piece_width, piece_height, piece_type, include_req,
                  rotate, last, output ready);
endinterface

interface grp_res_if;
    logic                     valid;
    logic                     ready;
    logic [1:0]               kind;
    logic [grp_pkg::CW-1:0]   pos_x;
    logic [grp_pkg::CW-1:0]   pos_y;
    logic [grp_pkg::CW-1:0]   rect_width;
    logic [grp_pkg::CW-1:0]   rect_height;
    logic signed [10:0]       piece_id;
    logic                     table_overflow;
    logic                     end_of_run;
    modport source (output valid, kind, pos_x, pos_y, rect_width, rect_height, piece_id,
                    table_overflow, end_of_run, input ready);
    modport sink (input valid, kind, pos_x, pos_y, rect_width, rect_height, piece_id,
                  table_overflow, end_of_run, output ready);
endinterface

interface grp_cfg_if;
    logic                     valid;
    logic                     ready;
    logic [1:0]               index;
    logic [grp_pkg::CW-1:0]   data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/grp_cell.sv =====
// one cell of the free rectangle chain: holds a rectangle and runs one
// best-fit step on the probe passing by; depends on grp_pkg
module grp_cell #(
    parameter int IDX = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  grp_pkg::t_cell_ctl i_ctl,
    input  grp_pkg::t_slot     i_prev,
    input  grp_pkg::t_slot     i_next,
    input  grp_pkg::t_probe    i_probe,
    output grp_pkg::t_slot     o_slot,
    output grp_pkg::t_probe    o_probe
);
    grp_pkg::t_slot  r_slot, n_slot;
    grp_pkg::t_probe r_probe, n_probe;

    logic                   w_fit;
    logic [grp_pkg::CW-1:0] w_dw, w_dh;
    logic                   w_take;

    function automatic logic IDX_BITS_GE();
        return grp_pkg::IDX_BITS'(IDX) >= i_ctl.rm_idx;
    endfunction

    always_comb begin
        n_slot = r_slot;
        case (i_ctl.op)
            grp_pkg::OP_PUSH:   n_slot = i_prev;
            grp_pkg::OP_POP:    n_slot = i_next;
            grp_pkg::OP_REMOVE: begin
                if (IDX_BITS_GE()) n_slot = i_next;
            end
            grp_pkg::OP_CLEAR:  n_slot.v = 1'b0;
            default:            n_slot = r_slot;
        endcase
    end

    always_comb begin
        w_fit  = r_slot.v && (i_ctl.w <= r_slot.r.w) && (i_ctl.h <= r_slot.r.h);
        w_dw   = r_slot.r.w - i_ctl.w;
        w_dh   = r_slot.r.h - i_ctl.h;
        // one exact side wins unless worse on its free side against a one-sided best
        if (w_dw == '0)
            w_take = (w_dh <= i_probe.dhmin) || (i_probe.dwmin != '0 && i_probe.dhmin != '0);
        else if (w_dh == '0)
            w_take = (w_dw <= i_probe.dwmin) || (i_probe.dwmin != '0 && i_probe.dhmin != '0);
        else
            w_take = (w_dw < i_probe.dwmin) || (w_dh < i_probe.dhmin);
        n_probe = i_probe;
        if (!i_probe.done && w_fit) begin
            if (w_dw == '0 && w_dh == '0) begin
                n_probe.done  = 1'b1;
                n_probe.found = 1'b1;
                n_probe.idx   = grp_pkg::IDX_BITS'(IDX);
                n_probe.r     = r_slot.r;
            end else if (w_take) begin
                n_probe.dwmin = w_dw;
                n_probe.dhmin = w_dh;
                n_probe.found = 1'b1;
                n_probe.idx   = grp_pkg::IDX_BITS'(IDX);
                n_probe.r     = r_slot.r;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot.v <= 1'b0;
        end else begin
            r_slot.v <= n_slot.v;
        end
        r_slot.r <= n_slot.r;
        r_probe  <= n_probe;
    end

    assign o_slot  = r_slot;
    assign o_probe = r_probe;
endmodule

// ===== rtl/guillotine_rect_packer.sv =====
// top level of the guillotine rectangle packer: sequencer, pattern state,
// output register and the chain of free rectangle cells
// depends on grp_pkg, grp_if.sv and grp_cell
//
//  channel  | dir | signals                                   | accepted when
//  i_item   | in  | piece sides, type, include, rotate, last  | valid && ready
//  o_res    | out | kind, position, size, id, overflow, eor   | valid && ready
//  i_cfg    | in  | index, data (sheet width, height)         | valid && ready
//
// a piece that reaches the free table waits while the probe runs down the cell
// chain, then is placed, up to two remainders are pushed and one result is
// sent; the last piece also sends one result per free rectangle and per
// external strip. reset is synchronous; the table needs no clearing pass.
// a stalled result holds the sequencer in its state.
module guillotine_rect_packer #(
    parameter int FREE_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    grp_item_if.sink    i_item,
    grp_res_if.source   o_res,
    grp_cfg_if.sink     i_cfg
);
    localparam int CW  = grp_pkg::CW;
    localparam int CNW = $clog2(FREE_DEPTH + 1);
    localparam int SCW = $clog2(FREE_DEPTH);

    grp_pkg::t_state r_st, n_st;

    logic [CW-1:0]  r_sheet_w, r_sheet_h;
    logic [CW-1:0]  r_w, r_h, n_w, n_h;
    logic [10:0]    r_id, n_id;
    logic           r_last, n_last, r_ok, n_ok, r_placed, n_placed;
    logic [CW-1:0]  r_px, r_py, n_px, n_py;
    grp_pkg::t_rect r_p1, r_p2, n_p1, n_p2;
    logic           r_p1v, r_p2v, n_p1v, n_p2v;
    logic [CW-1:0]  r_pw, r_ph, n_pw, n_ph;
    logic           r_started, n_started, r_ovf, n_ovf, r_ext, n_ext;
    logic [CNW-1:0] r_count, n_count;
    logic [SCW-1:0] r_cnt, n_cnt;

    logic           r_ov, n_ov;
    logic [1:0]     r_kind, n_kind;
    grp_pkg::t_rect r_orect, n_orect;
    logic [10:0]    r_oid, n_oid;
    logic           r_oflag, n_oflag, r_oeor, n_oeor;

    grp_pkg::t_cell_ctl w_ctl;
    grp_pkg::t_slot     w_push;
    grp_pkg::t_slot     w_slot [FREE_DEPTH];
    grp_pkg::t_probe    w_probe [FREE_DEPTH+1];

    logic w_out_free, w_accept, w_clear, w_both, w_eor;
    logic [1:0] w_ext_n;
    logic [CW:0] w_down_sum, w_right_sum;
    grp_pkg::t_probe w_pe;
    logic [FREE_DEPTH-1:0] w_valid;

    assign w_out_free = !r_ov || o_res.ready;
    assign w_accept   = i_item.valid && i_item.ready;
    assign i_item.ready = (r_st == grp_pkg::S_IDLE);
    assign i_cfg.ready  = 1'b1;
    assign w_pe = w_probe[FREE_DEPTH];

    assign w_both  = (r_pw < r_sheet_w) && (r_ph < r_sheet_h);
    assign w_ext_n = !r_started ? 2'd1 :
                     2'((r_pw < r_sheet_w) ? 1 : 0) + 2'((r_ph < r_sheet_h) ? 1 : 0);
    assign w_down_sum  = {1'b0, r_ph} + {1'b0, r_h};
    assign w_right_sum = {1'b0, r_pw} + {1'b0, r_w};

    // first probe starts from the sheet size as the slack to beat
    assign w_probe[0] = '{dwmin: r_sheet_w, dhmin: r_sheet_h, default: '0};

    genvar gi;
    generate
        for (gi = 0; gi < FREE_DEPTH; gi++) begin : g_cell
            grp_pkg::t_slot w_prev, w_next;
            if (gi == 0) begin : g_head
                assign w_prev = w_push;
            end else begin : g_mid
                assign w_prev = w_slot[gi-1];
            end
            if (gi == FREE_DEPTH - 1) begin : g_tail
                assign w_next = '0;
            end else begin : g_body
                assign w_next = w_slot[gi+1];
            end
            grp_cell #(.IDX(gi)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_prev  (w_prev),
                .i_next  (w_next),
                .i_probe (w_probe[gi]),
                .o_slot  (w_slot[gi]),
                .o_probe (w_probe[gi+1])
            );
            assign w_valid[gi] = w_slot[gi].v;
        end
    endgenerate

    // next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            grp_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (!n_ok)           n_st = grp_pkg::S_PIECE;
                    else if (!r_started) n_st = grp_pkg::S_PLACE;
                    else                 n_st = grp_pkg::S_SCAN;
                end
            end
            grp_pkg::S_SCAN:  if (r_cnt == SCW'(FREE_DEPTH - 1)) n_st = grp_pkg::S_PLACE;
            grp_pkg::S_PLACE: n_st = n_p1v ? grp_pkg::S_PUSH1 : grp_pkg::S_PIECE;
            grp_pkg::S_PUSH1: n_st = r_p2v ? grp_pkg::S_PUSH2 : grp_pkg::S_PIECE;
            grp_pkg::S_PUSH2: n_st = grp_pkg::S_PIECE;
            grp_pkg::S_PIECE: begin
                if (w_out_free) begin
                    if (!r_last || w_eor) n_st = grp_pkg::S_IDLE;
                    else if (w_slot[0].v) n_st = grp_pkg::S_DUMP;
                    else                  n_st = grp_pkg::S_EXT;
                end
            end
            grp_pkg::S_DUMP: begin
                if (w_out_free && !w_slot[1].v)
                    n_st = w_eor ? grp_pkg::S_IDLE : grp_pkg::S_EXT;
            end
            grp_pkg::S_EXT:  if (w_out_free && w_eor) n_st = grp_pkg::S_IDLE;
            default:         n_st = grp_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_w = r_w; n_h = r_h; n_id = r_id; n_last = r_last; n_ok = r_ok;
        n_placed = r_placed; n_px = r_px; n_py = r_py;
        n_p1 = r_p1; n_p2 = r_p2; n_p1v = r_p1v; n_p2v = r_p2v;
        n_pw = r_pw; n_ph = r_ph; n_started = r_started; n_ovf = r_ovf;
        n_ext = r_ext; n_count = r_count; n_cnt = r_cnt;
        n_ov = r_ov && !o_res.ready;
        n_kind = r_kind; n_orect = r_orect; n_oid = r_oid; n_oflag = r_oflag;
        n_oeor = r_oeor;
        w_ctl.op = grp_pkg::OP_HOLD;
        w_ctl.rm_idx = w_pe.idx;
        w_ctl.w = r_w;
        w_ctl.h = r_h;
        w_push.v = 1'b1;
        w_push.r = r_p1;
        w_clear = 1'b0;
        w_eor = 1'b0;

        unique case (r_st)
            grp_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_w  = i_item.rotate ? i_item.piece_height : i_item.piece_width;
                    n_h  = i_item.rotate ? i_item.piece_width : i_item.piece_height;
                    n_id = i_item.rotate ? 11'(-{1'b0, i_item.piece_type})
                                         : {1'b0, i_item.piece_type};
                    n_last = i_item.last;
                    n_ok = i_item.include_req && n_w != '0 && n_h != '0
                        && n_w <= r_sheet_w && n_h <= r_sheet_h;
                    n_placed = 1'b0;
                    n_px = '0;
                    n_py = '0;
                    n_p1v = 1'b0;
                    n_p2v = 1'b0;
                    n_cnt = '0;
                    n_ext = 1'b0;
                end
            end
            grp_pkg::S_SCAN: n_cnt = r_cnt + SCW'(1);
            grp_pkg::S_PLACE: begin
                if (!r_started) begin
                    n_started = 1'b1;
                    n_pw = r_w;
                    n_ph = r_h;
                    n_placed = 1'b1;
                end else if (w_pe.found) begin
                    w_ctl.op = grp_pkg::OP_REMOVE;
                    n_count = r_count - CNW'(1);
                    n_px = w_pe.r.x;
                    n_py = w_pe.r.y;
                    n_placed = 1'b1;
                    if (r_w < w_pe.r.w && r_h < w_pe.r.h) begin
                        n_p1 = '{x: w_pe.r.x, y: w_pe.r.y + r_h, w: w_pe.r.w,
                                 h: w_pe.r.h - r_h};
                        n_p2 = '{x: w_pe.r.x + r_w, y: w_pe.r.y, w: w_pe.r.w - r_w, h: r_h};
                        n_p1v = 1'b1;
                        n_p2v = 1'b1;
                    end else if (r_h < w_pe.r.h) begin
                        n_p1 = '{x: w_pe.r.x, y: w_pe.r.y + r_h, w: r_w, h: w_pe.r.h - r_h};
                        n_p1v = 1'b1;
                    end else if (r_w < w_pe.r.w) begin
                        n_p1 = '{x: w_pe.r.x + r_w, y: w_pe.r.y, w: w_pe.r.w - r_w, h: r_h};
                        n_p1v = 1'b1;
                    end
                end else if (w_down_sum <= {1'b0, r_sheet_h}) begin
                    n_px = '0;
                    n_py = r_ph;
                    n_placed = 1'b1;
                    if (r_pw > r_w) begin
                        n_p1 = '{x: r_w, y: r_ph, w: r_pw - r_w, h: r_h};
                        n_p1v = 1'b1;
                    end else if (r_w > r_pw) begin
                        n_p1 = '{x: r_pw, y: '0, w: r_w - r_pw, h: r_ph};
                        n_p1v = 1'b1;
                        n_pw = r_w;
                    end
                    n_ph = w_down_sum[CW-1:0];
                end else if (w_right_sum <= {1'b0, r_sheet_w}) begin
                    n_px = r_pw;
                    n_py = '0;
                    n_placed = 1'b1;
                    if (r_ph > r_h) begin
                        n_p1 = '{x: r_pw, y: r_h, w: r_w, h: r_ph - r_h};
                        n_p1v = 1'b1;
                    end else if (r_h > r_ph) begin
                        n_p1 = '{x: '0, y: r_ph, w: r_pw, h: r_h - r_ph};
                        n_p1v = 1'b1;
                        n_ph = r_h;
                    end
                    n_pw = w_right_sum[CW-1:0];
                end
            end
            grp_pkg::S_PUSH1, grp_pkg::S_PUSH2: begin
                w_push.r = (r_st == grp_pkg::S_PUSH1) ? r_p1 : r_p2;
                if (r_count == CNW'(FREE_DEPTH)) begin
                    n_ovf = 1'b1;
                end else begin
                    w_ctl.op = grp_pkg::OP_PUSH;
                    n_count = r_count + CNW'(1);
                end
            end
            grp_pkg::S_PIECE: begin
                w_eor = !r_last || (!w_slot[0].v && w_ext_n == 2'd0);
                if (w_out_free) begin
                    n_ov = 1'b1;
                    n_kind = r_placed ? grp_pkg::KIND_PLACED : grp_pkg::KIND_SKIPPED;
                    n_orect = '{x: r_px, y: r_py, w: r_w, h: r_h};
                    n_oid = r_id;
                    n_oflag = r_ovf;
                    n_oeor = w_eor;
                    w_clear = r_last && w_eor;
                end
            end
            grp_pkg::S_DUMP: begin
                w_eor = !w_slot[1].v && w_ext_n == 2'd0;
                if (w_out_free) begin
                    n_ov = 1'b1;
                    n_kind = grp_pkg::KIND_INTERNAL;
                    n_orect = w_slot[0].r;
                    n_oid = '0;
                    n_oflag = r_ovf;
                    n_oeor = w_eor;
                    w_ctl.op = grp_pkg::OP_POP;
                    n_count = r_count - CNW'(1);
                    w_clear = w_eor;
                end
            end
            grp_pkg::S_EXT: begin
                w_eor = r_ext || !(r_started && w_both);
                if (w_out_free) begin
                    n_ov = 1'b1;
                    n_kind = grp_pkg::KIND_EXTERNAL;
                    n_oid = '0;
                    n_oflag = r_ovf;
                    n_oeor = w_eor;
                    n_ext = 1'b1;
                    if (!r_started)
                        n_orect = '{x: '0, y: '0, w: r_sheet_w, h: r_sheet_h};
                    else if (!r_ext && r_pw < r_sheet_w)
                        n_orect = '{x: r_pw, y: '0, w: r_sheet_w - r_pw,
                                    h: w_both ? r_ph : r_sheet_h};
                    else
                        n_orect = '{x: '0, y: r_ph, w: r_sheet_w, h: r_sheet_h - r_ph};
                    w_clear = w_eor;
                end
            end
            default: ;
        endcase

        if (w_clear) begin
            w_ctl.op = grp_pkg::OP_CLEAR;
            n_count = '0;
            n_pw = '0;
            n_ph = '0;
            n_started = 1'b0;
            n_ovf = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= grp_pkg::S_IDLE;
            r_sheet_w <= CW'(1024);
            r_sheet_h <= CW'(1024);
            r_pw      <= '0;
            r_ph      <= '0;
            r_started <= 1'b0;
            r_ovf     <= 1'b0;
            r_count   <= '0;
            r_ov      <= 1'b0;
        end else begin
            r_st      <= n_st;
            r_pw      <= n_pw;
            r_ph      <= n_ph;
            r_started <= n_started;
            r_ovf     <= n_ovf;
            r_count   <= n_count;
            r_ov      <= n_ov;
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.index == grp_pkg::REG_SHEET_W) r_sheet_w <= i_cfg.data;
                else if (i_cfg.index == grp_pkg::REG_SHEET_H) r_sheet_h <= i_cfg.data;
            end
        end
        r_w <= n_w; r_h <= n_h; r_id <= n_id; r_last <= n_last; r_ok <= n_ok;
        r_placed <= n_placed; r_px <= n_px; r_py <= n_py;
        r_p1 <= n_p1; r_p2 <= n_p2; r_p1v <= n_p1v; r_p2v <= n_p2v;
        r_ext <= n_ext; r_cnt <= n_cnt;
        r_kind <= n_kind; r_orect <= n_orect; r_oid <= n_oid;
        r_oflag <= n_oflag; r_oeor <= n_oeor;
    end

    assign o_res.valid          = r_ov;
    assign o_res.kind           = r_kind;
    assign o_res.pos_x          = r_orect.x;
    assign o_res.pos_y          = r_orect.y;
    assign o_res.rect_width     = r_orect.w;
    assign o_res.rect_height    = r_orect.h;
    assign o_res.piece_id       = r_oid;
    assign o_res.table_overflow = r_oflag;
    assign o_res.end_of_run     = r_oeor;

    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == CNW'($countones(w_valid)))
        else $error("free count disagrees with valid cells");

    a_dump_has_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == grp_pkg::S_DUMP |-> w_slot[0].v)
        else $error("dumping an empty table");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNW'(FREE_DEPTH))
        else $error("free count beyond table depth");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == grp_pkg::S_EXT && w_out_free && w_eor) |=> (r_count == '0 && !r_started))
        else $error("state not cleared after end of job");
endmodule
